/* sv/rdd_pkg.sv */
// Shared types and constants for the ROM descriptor deframer.
// Request structs for both channels, status codes, and register map.
// No dependencies.
package rdd_pkg;

    localparam int WORD_W     = 32;
    localparam int BUF_W      = 16;
    localparam int LEN_W      = 14;
    localparam int HALF_W     = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_SWAP         = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_BUFFER_WORDS = 3'd4;

    localparam logic [WORD_W-1:0] HDR_HIGH_MASK = 32'hffff_0000;
    localparam int                TYPE_LSB      = 14;

    typedef enum logic [2:0] {
        ST_HEADER    = 3'd0,
        ST_PAYLOAD   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_END       = 3'd3,
        ST_BAD_HDR   = 3'd4,
        ST_TRUNCATED = 3'd5,
        ST_IGNORED   = 3'd6
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start_req;
    } t_in_req;

    typedef struct packed {
        t_status           status;
        logic [1:0]        desc_type;
        logic [LEN_W-1:0]  desc_words;
        logic [HALF_W-1:0] payload;
        logic              first_of_desc;
        logic              last_of_desc;
    } t_out_req;

    function automatic logic [WORD_W-1:0] byte_reverse(input logic [WORD_W-1:0] v);
        byte_reverse = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* sv/rdd_front.sv */
// Front end of the deframer: takes input requests and normalizes byte order.
// Pushes the swapped word with its start flag into the queue.
// Depends on rdd_pkg.
module rdd_front
    import rdd_pkg::*;
(
    input  logic    i_in_valid,
    input  t_in_req i_in_req,
    output logic    o_in_stall,
    input  logic    i_swap,
    input  logic    i_q_full,
    output logic    o_q_push,
    output t_in_req o_q_req
);

    assign o_in_stall        = i_q_full;
    assign o_q_push          = i_in_valid & ~i_q_full;
    assign o_q_req.start_req = i_in_req.start_req;
    assign o_q_req.word      = i_swap ? byte_reverse(i_in_req.word) : i_in_req.word;

endmodule

/* sv/rdd_queue.sv */
// Short request queue between the front and back ends of the deframer.
// Register-based ring buffer with full and empty flags.
// Depends on rdd_pkg.
module rdd_queue
    import rdd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_in_req i_push_req,
    output logic    o_full,
    input  logic    i_pop,
    output t_in_req o_pop_req,
    output logic    o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_in_req          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_pop_req = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

/* sv/rdd_back.sv */
// Back end of the deframer: parse state machine and output register.
// Pops one queued word per cycle while not empty and not stalled,
// and produces one result request for it. Depends on rdd_pkg.
module rdd_back
    import rdd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BUF_W-1:0] i_buffer_words,
    input  logic             i_q_empty,
    input  t_in_req          i_q_req,
    output logic             o_q_pop,
    output logic             o_out_valid,
    output t_out_req         o_out_req,
    input  logic             i_out_stall
);

    logic [BUF_W-1:0] r_word_pos, n_word_pos;
    logic [LEN_W-1:0] r_remaining, n_remaining;
    logic [1:0]       r_cur_type, n_cur_type;
    logic             r_first_pending, n_first_pending;
    logic             r_stopped, n_stopped;
    logic             r_out_valid;
    t_out_req         r_out_req, n_out_req;

    logic [BUF_W-1:0] pos_e;
    logic [LEN_W-1:0] rem_e;
    logic [1:0]       type_e;
    logic             first_e;
    logic             stop_e;
    logic [BUF_W-1:0] pos_inc;
    logic [BUF_W-1:0] avail;
    logic [WORD_W-1:0] v;
    logic [1:0]       hdr_type;
    logic [LEN_W-1:0] hdr_len;

    assign o_q_pop     = ~i_q_empty & (~r_out_valid | ~i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign v        = i_q_req.word;
    assign hdr_type = v[TYPE_LSB+1:TYPE_LSB];
    assign hdr_len  = v[LEN_W-1:0];

    always_comb begin
        pos_e   = i_q_req.start_req ? '0 : r_word_pos;
        rem_e   = i_q_req.start_req ? '0 : r_remaining;
        type_e  = i_q_req.start_req ? '0 : r_cur_type;
        first_e = i_q_req.start_req ? 1'b0 : r_first_pending;
        stop_e  = i_q_req.start_req ? 1'b0 : r_stopped;
        pos_inc = pos_e + BUF_W'(1);
        avail   = i_buffer_words - pos_inc;

        n_word_pos      = pos_e;
        n_remaining     = rem_e;
        n_cur_type      = type_e;
        n_first_pending = first_e;
        n_stopped       = stop_e;
        n_out_req       = '0;
        n_out_req.status = ST_IGNORED;

        if (!stop_e && (pos_e < i_buffer_words)) begin
            n_word_pos = pos_inc;
            if (rem_e != '0) begin
                n_out_req.status        = ST_PAYLOAD;
                n_out_req.desc_type     = type_e;
                n_out_req.payload       = v[HALF_W-1:0];
                n_out_req.first_of_desc = first_e;
                n_out_req.last_of_desc  = (rem_e == LEN_W'(1));
                n_remaining             = rem_e - LEN_W'(1);
                n_first_pending         = 1'b0;
            end else if ((v & HDR_HIGH_MASK) != '0) begin
                n_out_req.status = ST_BAD_HDR;
                n_stopped        = 1'b1;
            end else begin
                n_out_req.desc_type  = hdr_type;
                n_out_req.desc_words = hdr_len;
                priority if (hdr_type == 2'd0) begin
                    n_out_req.status = ST_END;
                    n_stopped        = 1'b1;
                end else if (BUF_W'(hdr_len) > avail) begin
                    n_out_req.status = ST_TRUNCATED;
                    n_stopped        = 1'b1;
                end else if (hdr_len == '0) begin
                    n_out_req.status = ST_EMPTY;
                end else begin
                    n_out_req.status = ST_HEADER;
                    n_remaining      = hdr_len;
                    n_cur_type       = hdr_type;
                    n_first_pending  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos      <= '0;
            r_remaining     <= '0;
            r_cur_type      <= '0;
            r_first_pending <= 1'b0;
            r_stopped       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_word_pos      <= n_word_pos;
                r_remaining     <= n_remaining;
                r_cur_type      <= n_cur_type;
                r_first_pending <= n_first_pending;
                r_stopped       <= n_stopped;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_req <= n_out_req;
        end
    end

endmodule

/* sv/rom_descriptor_deframer_core.sv */
// Top level of the ROM descriptor deframer: APB registers, front, queue, back.
// Depends on rdd_pkg, rdd_front, rdd_queue, rdd_back.
//
//   channel   valid        payload     stall        direction
//   input     i_in_valid   i_in_req    o_in_stall   ROM word requests in
//   output    o_out_valid  o_out_req   i_out_stall  one result request per word
//   config    psel/penable paddr/pwdata pready=1    APB register writes/reads
//
// One word per cycle sustained while the output is not stalled; a word passes
// through the queue entry and then the back-end output register.
// Synchronous active-low reset clears parse state, queue and registers.
// Input stalls only when the queue is full; output stalls back up through it.
module rom_descriptor_deframer_core
    import rdd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_req            i_in_req,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_req           o_out_req,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic             r_swap;
    logic [BUF_W-1:0] r_buffer_words;
    logic             cfg_wr;

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    t_in_req q_push_req;
    t_in_req q_pop_req;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap         <= 1'b0;
            r_buffer_words <= '0;
        end else if (cfg_wr) begin
            if (paddr == ADDR_SWAP) begin
                r_swap <= pwdata[0];
            end
            if (paddr == ADDR_BUFFER_WORDS) begin
                r_buffer_words <= pwdata[BUF_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_SWAP) begin
            prdata = PDATA_W'(r_swap);
        end else if (paddr == ADDR_BUFFER_WORDS) begin
            prdata = PDATA_W'(r_buffer_words);
        end
    end

    rdd_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .i_swap     (r_swap),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_req    (q_push_req)
    );

    rdd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_req (q_push_req),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_req  (q_pop_req),
        .o_empty    (q_empty)
    );

    rdd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_buffer_words (r_buffer_words),
        .i_q_empty      (q_empty),
        .i_q_req        (q_pop_req),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .o_out_req      (o_out_req),
        .i_out_stall    (i_out_stall)
    );

endmodule
